[sv/sorted_min_priority_queue_defines.svh]
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_defines
// Assertion helpers used by the sorted queue top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_MIN_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SMPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted queue check failed");

// Next-cycle implication, checked out of reset.
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted queue check failed");

`endif

[sv/smpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg
// Types and constants for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam data_t EMPTY_VALUE = '1;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic enq;
        logic deq;
    } smpq_ctrl_t;

    function automatic logic lower_than(input data_t a, input data_t b);
        lower_than = (a < b);
    endfunction

endpackage
`default_nettype wire

[sv/smpq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: compare, keep, take the new value, or
// take a neighbor's value.
// ----------------------------------------------------------------------------
module smpq_cell
    import smpq_pkg::*;
(
    input  logic       clk,
    input  smpq_ctrl_t ctrl,
    input  data_t      ins_value,
    input  logic       occupied,
    input  data_t      left_value,
    input  logic       left_gt,
    input  data_t      right_value,
    output data_t      value,
    output logic       gt
);

    data_t value_reg;
    data_t value_next;

    // An empty slot counts as greater than anything, so the first free slot
    // catches the insert.
    assign gt    = !occupied || lower_than(ins_value, value_reg);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.enq && gt)
        begin
            if (left_gt)
                value_next = left_value;
            else
                value_next = ins_value;
        end
        else if (ctrl.deq)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
`default_nettype wire

[sv/sorted_min_priority_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// The result of a request is registered and shows on the output in the cycle after it is taken.
// Throughput: one request per cycle while the input is not stalled; every cell updates in parallel.
// The input stalls only while a finished result waits under output stall.
// Reset clears the count and the output valid; slot contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Minimum priority queue kept sorted in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
`include "sorted_min_priority_queue_defines.svh"

module sorted_min_priority_queue
    import smpq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    mode,
    input  logic signed [DATA_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [DATA_W-1:0] removed_value,
    output logic [1:0]              status,
    output logic [OCC_W-1:0]        occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    data_t            removed_reg;
    data_t            removed_next;
    status_t          status_reg;
    status_t          status_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    logic       accept;
    logic       full;
    logic       empty;
    smpq_ctrl_t ctrl;

    data_t vals [CAPACITY];
    logic  gts  [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign ctrl.enq = accept && (mode == MODE_ENQ) && !full;
    assign ctrl.deq = accept && (mode == MODE_DEQ) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            data_t left_v;
            logic  left_g;
            data_t right_v;

            if (gi == 0)
            begin : g_head
                assign left_v = value;
                assign left_g = 1'b0;
            end
            else
            begin : g_body
                assign left_v = vals[gi-1];
                assign left_g = gts[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_v = vals[gi];
            end
            else
            begin : g_mid
                assign right_v = vals[gi+1];
            end

            smpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .ins_value   (value),
                .occupied    (CNT_W'(gi) < count_reg),
                .left_value  (left_v),
                .left_gt     (left_g),
                .right_value (right_v),
                .value       (vals[gi]),
                .gt          (gts[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        removed_next   = removed_reg;
        status_next    = status_reg;
        occ_next       = occ_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            removed_next   = '0;
            status_next    = ST_OK;
            if (mode == MODE_ENQ)
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                if (empty)
                begin
                    removed_next = EMPTY_VALUE;
                    status_next  = ST_EMPTY;
                end
                else
                begin
                    removed_next = vals[0];
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            occ_next = OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= removed_next;
        status_reg  <= status_next;
        occ_reg     <= occ_next;
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign occupancy     = occ_reg;

    `SMPQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SMPQ_ASSERT_NEXT(a_enq_grows, clk, rst_n, ctrl.enq,
        count_reg == $past(count_reg) + CNT_W'(1))
    `SMPQ_ASSERT_IMP(a_head_sorted, clk, rst_n, count_reg >= CNT_W'(2),
        !lower_than(vals[1], vals[0]))
    `SMPQ_ASSERT_NEXT(a_deq_shift, clk, rst_n, ctrl.deq && count_reg >= CNT_W'(2),
        vals[0] == $past(vals[1]))
    `SMPQ_ASSERT_IMP(a_empty_result, clk, rst_n, out_valid_reg && status_reg == ST_EMPTY,
        removed_reg == EMPTY_VALUE && occ_reg == '0)

endmodule
`default_nettype wire

[tb/smpq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_checker
// Watches both channels of the sorted minimum priority queue, keeps its own
// sorted copy of the stored values, predicts the result of every accepted
// request and compares each delivered result against the oldest prediction.
// ----------------------------------------------------------------------------
module smpq_checker
    import smpq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     mode,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [DATA_W-1:0] removed_value,
    input  logic [1:0]               status,
    input  logic [OCC_W-1:0]         occupancy,
    output int                       mismatches,
    output int                       outstanding
);

    typedef struct {
        data_t             removed;
        status_t           status;
        logic [OCC_W-1:0]  occupancy;
    } queue_result_t;

    data_t         held_values[$];
    queue_result_t pending_results[$];

    function automatic queue_result_t apply_request(input logic op, input data_t v);
        queue_result_t r;
        int            slot;
        r.removed = '0;
        r.status  = ST_OK;
        if (op == MODE_ENQ)
        begin
            if (held_values.size() >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // place after every equal value already held
                slot = held_values.size();
                while (slot > 0 && v < held_values[slot-1])
                    slot--;
                held_values.insert(slot, v);
            end
        end
        else
        begin
            if (held_values.size() == 0)
            begin
                r.removed = EMPTY_VALUE;
                r.status  = ST_EMPTY;
            end
            else
            begin
                r.removed = held_values.pop_front();
            end
        end
        r.occupancy = OCC_W'(held_values.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        queue_result_t want;
        if (!rst_n)
        begin
            held_values.delete();
            pending_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // compare before predicting: a result never belongs to a request
            // taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("smpq_checker: extra result: value %0d status %0d occ %0d",
                                 removed_value, status, occupancy);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (removed_value !== want.removed || status !== want.status ||
                        occupancy !== want.occupancy)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("smpq_checker: mismatch at %0t: expected %0d/%0d/%0d",
                                     $realtime, want.removed, want.status, want.occupancy);
                            $display("smpq_checker:   actual %0d/%0d/%0d",
                                     removed_value, status, occupancy);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(apply_request(mode, value));
            outstanding = pending_results.size();
        end
    end

endmodule

[tb/tb_sorted_min_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_min_priority_queue
// Drives enqueue and dequeue requests into the sorted queue with random gaps
// and random output stalls; a checker module beside the block predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sorted_min_priority_queue;
    import smpq_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int RANDOM_ITEMS   = 900;
    localparam int CALM_ITEMS     = 120;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam data_t MAX_VALUE = 32'sh7fff_ffff;
    localparam data_t MIN_VALUE = 32'sh8000_0000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     mode;
    data_t                    value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] removed_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;

    int    mismatches;
    int    outstanding;
    int    idle_cycles;
    int    gap_odds;
    bit    calm;
    data_t last_value;

    sorted_min_priority_queue #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .removed_value (removed_value),
        .status        (status),
        .occupancy     (occupancy)
    );

    smpq_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .removed_value (removed_value),
        .status        (status),
        .occupancy     (occupancy),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mix wide random values with a narrow band and repeats so that
    // duplicates and ties show up often.
    function automatic data_t pick_value();
        data_t v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $signed($urandom_range(0, 16)) - 8;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       v = MAX_VALUE;
                    1:       v = MIN_VALUE;
                    2:       v = '0;
                    default: v = -1;
                endcase
            end
            8:          v = $urandom_range(0, 1) ? MAX_VALUE - $urandom_range(0, 3)
                                                 : MIN_VALUE + $urandom_range(0, 3);
            default:    v = last_value;
        endcase
        last_value = v;
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_request(input logic op, input data_t v);
        int gap;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            mode     <= 1'($urandom_range(0, 1));
            value    <= $urandom;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Output stalls: bursts of random length separated by quiet stretches.
    initial
    begin : stall_gen
        int stall_left;
        int quiet_left;
        out_stall  = 1'b0;
        stall_left = 0;
        quiet_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (quiet_left > 0)
                quiet_left--;
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 12);
                quiet_left = $urandom_range(0, 40);
            end
            out_stall <= (stall_left > 0);
        end
    end

    initial
    begin : stimulus
        int k;
        int enq_pct;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_ENQ;
        value      = '0;
        calm       = 1'b0;
        gap_odds   = 4;
        last_value = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // dequeue from empty, then a tie against a single held value
        push_request(MODE_DEQ, 32'sd123);
        push_request(MODE_ENQ, 32'sd5);
        push_request(MODE_ENQ, 32'sd5);
        push_request(MODE_DEQ, '0);
        push_request(MODE_ENQ, MAX_VALUE);
        push_request(MODE_ENQ, MIN_VALUE);
        push_request(MODE_ENQ, -1);
        push_request(MODE_ENQ, '0);
        // fill to capacity with many ties, then enqueue into a full queue
        for (k = 0; k < CAPACITY - 5; k++)
            push_request(MODE_ENQ, (k % 3) - 1);
        push_request(MODE_ENQ, 32'sd7);
        push_request(MODE_DEQ, '0);
        push_request(MODE_ENQ, MAX_VALUE);

        enq_pct = 50;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 25;
                    1:       enq_pct = 50;
                    default: enq_pct = 75;
                endcase
                case ($urandom_range(0, 3))
                    0:       gap_odds = 0;
                    1:       gap_odds = 2;
                    2:       gap_odds = 4;
                    default: gap_odds = 8;
                endcase
            end
            calm = (k >= RANDOM_ITEMS - CALM_ITEMS);
            push_request(($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ, pick_value());
        end
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("tb_sorted_min_priority_queue: PASS");
        else
            $display("tb_sorted_min_priority_queue: FAIL");
        $finish;
    end

    // Count cycles with no request taken and no result delivered.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("tb_sorted_min_priority_queue: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
